FILE: sv/otmfd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// otmfd_pkg
// Shared types, register indexes, reset values and defaults for the
// Manchester frame decoder.
// ---------------------------------------------------------------------------
package otmfd_pkg;

   localparam int DEF_DATA_BITS     = 32;
   localparam int DEF_DURATION_BITS = 15;

   localparam int CFG_W   = 15;
   localparam int TOL_W   = 10;
   localparam int INDEX_W = 3;

   localparam logic [CFG_W-1:0] RST_FIRST_SHORT  = CFG_W'(550);
   localparam logic [CFG_W-1:0] RST_FIRST_LONG   = CFG_W'(1060);
   localparam logic [CFG_W-1:0] RST_SECOND_SHORT = CFG_W'(470);
   localparam logic [CFG_W-1:0] RST_SECOND_LONG  = CFG_W'(984);
   localparam logic [TOL_W-1:0] RST_SNAP_TOL     = TOL_W'(30);
   localparam logic [CFG_W-1:0] RST_SHORT_PULSE  = CFG_W'(150);
   localparam logic [CFG_W-1:0] RST_SLOT_SPLIT   = CFG_W'(700);
   localparam logic [TOL_W-1:0] RST_GLITCH       = TOL_W'(30);

   typedef enum logic [INDEX_W-1:0] {
      REG_FIRST_SHORT  = 3'd0,
      REG_FIRST_LONG   = 3'd1,
      REG_SECOND_SHORT = 3'd2,
      REG_SECOND_LONG  = 3'd3,
      REG_SNAP_TOL     = 3'd4,
      REG_SHORT_PULSE  = 3'd5,
      REG_SLOT_SPLIT   = 3'd6,
      REG_GLITCH       = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_OK          = 2'd0,
      STATUS_GLITCH      = 2'd1,
      STATUS_LOW_START   = 2'd2,
      STATUS_SHORT_PULSE = 2'd3
   } status_type;

   typedef struct packed {
      logic [CFG_W-1:0] first_short;
      logic [CFG_W-1:0] first_long;
      logic [CFG_W-1:0] second_short;
      logic [CFG_W-1:0] second_long;
      logic [TOL_W-1:0] snap_tol;
      logic [CFG_W-1:0] short_pulse;
      logic [CFG_W-1:0] slot_split;
      logic [TOL_W-1:0] glitch;
   } cfg_type;

   typedef struct packed {
      logic last;
      logic glitch;
      logic below_first_short;
      logic short0;
      logic short1;
   } flags_type;

endpackage
`default_nettype wire

FILE: sv/otmfd_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// otmfd_front
// Input stage: takes a symbol, classifies its raw durations against the
// glitch, clamp and short pulse limits and holds it for the queue.
// ---------------------------------------------------------------------------
module otmfd_front
   import otmfd_pkg::*;
#(
   parameter int DURATION_BITS = DEF_DURATION_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cfg_type                  cfg,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_first_level,
   input  wire logic [DURATION_BITS-1:0] req_first_duration,
   input  wire logic                     req_second_level,
   input  wire logic [DURATION_BITS-1:0] req_second_duration,
   input  wire logic                     req_last_symbol,
   input  wire logic                     q_ready,
   output logic                          q_push,
   output logic                          lvl0,
   output logic [DURATION_BITS-1:0]      dur0,
   output logic                          lvl1,
   output logic [DURATION_BITS-1:0]      dur1,
   output flags_type                     flags
);

   localparam int UW = (DURATION_BITS > CFG_W) ? DURATION_BITS : CFG_W;

   logic                     valid_ff, valid_in;
   logic                     lvl0_ff, lvl1_ff;
   logic [DURATION_BITS-1:0] dur0_ff, dur1_ff;
   flags_type                flags_ff, flags_in;
   logic                     take;
   logic [UW-1:0]            d0_x, d1_x;

   assign req_stall = valid_ff && !q_ready;
   assign take      = req_valid && !req_stall;
   assign q_push    = valid_ff && q_ready;

   assign d0_x = UW'(req_first_duration);
   assign d1_x = UW'(req_second_duration);

   always_comb begin
      flags_in.last              = req_last_symbol;
      flags_in.glitch            = (d0_x < UW'(cfg.glitch)) || (d1_x < UW'(cfg.glitch));
      flags_in.below_first_short = d0_x < UW'(cfg.first_short);
      flags_in.short0            = d0_x < UW'(cfg.short_pulse);
      flags_in.short1            = d1_x < UW'(cfg.short_pulse);
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (q_push) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         lvl0_ff  <= req_first_level;
         dur0_ff  <= req_first_duration;
         lvl1_ff  <= req_second_level;
         dur1_ff  <= req_second_duration;
         flags_ff <= flags_in;
      end
   end

   assign lvl0  = lvl0_ff;
   assign dur0  = dur0_ff;
   assign lvl1  = lvl1_ff;
   assign dur1  = dur1_ff;
   assign flags = flags_ff;

endmodule
`default_nettype wire

FILE: sv/otmfd_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// otmfd_queue
// Two-entry queue between the input stage and the decode stage.
// ---------------------------------------------------------------------------
module otmfd_queue
   import otmfd_pkg::*;
#(
   parameter int WIDTH = 2 * DEF_DURATION_BITS + 2 + $bits(flags_type)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  ready,
   input  wire logic             pop,
   output logic                  valid,
   output logic [WIDTH-1:0]      head
);

   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign ready = count_ff != 2'd2;
   assign valid = count_ff != 2'd0;
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

FILE: sv/otmfd_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// otmfd_back
// Decode stage: error checks, duration snapping with carried error,
// half-bit slot counting, word assembly and the result register.
// ---------------------------------------------------------------------------
module otmfd_back
   import otmfd_pkg::*;
#(
   parameter int DATA_BITS     = DEF_DATA_BITS,
   parameter int DURATION_BITS = DEF_DURATION_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cfg_type                  cfg,
   input  wire logic                     q_valid,
   output logic                          q_pop,
   input  wire logic                     lvl0,
   input  wire logic [DURATION_BITS-1:0] dur0,
   input  wire logic                     lvl1,
   input  wire logic [DURATION_BITS-1:0] dur1,
   input  wire flags_type                flags,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [DATA_BITS-1:0]          rsp_frame_word,
   output logic [1:0]                    rsp_status
);

   localparam int W    = DURATION_BITS;
   localparam int UW   = (W > CFG_W) ? W : CFG_W;
   localparam int CW   = UW + 3;
   localparam int BC_W = $clog2(DATA_BITS + 2);

   function automatic logic [W-1:0] to_dur(input logic [CFG_W-1:0] v);
      return W'(v);
   endfunction

   function automatic logic in_win(input logic [W-1:0] len, input logic [CFG_W-1:0] base,
                                   input logic [TOL_W-1:0] tol);
      logic signed [CW-1:0] l, b, t;
      l = $signed(CW'(len));
      b = $signed(CW'(base));
      t = $signed(CW'(tol));
      return (l > b - t) && (l < b + t);
   endfunction

   function automatic logic below_long(input logic [W-1:0] len, input logic [CFG_W-1:0] lng,
                                       input logic [TOL_W-1:0] tol);
      logic signed [CW-1:0] l, b, t;
      l = $signed(CW'(len));
      b = $signed(CW'(lng));
      t = $signed(CW'(tol));
      return l < b - (t + t);
   endfunction

   function automatic logic [1:0] slots_of(input logic [W-1:0] d, input cfg_type c);
      logic [1:0] s;
      if (UW'(d) < UW'(c.glitch)) begin
         s = 2'd0;
      end else if (UW'(d) < UW'(c.slot_split)) begin
         s = 2'd1;
      end else begin
         s = 2'd2;
      end
      return s;
   endfunction

   logic [W-1:0]         carry_ff, carry_in;
   logic [1:0]           slot_ff, slot_in;
   logic [BC_W-1:0]      bits_ff, bits_in;
   logic [DATA_BITS-1:0] acc_ff, acc_in;
   status_type           err_ff, err_in;
   logic                 first_ff, first_in;
   logic                 stop_ff, stop_in;

   logic                 out_valid_ff, out_valid_in;
   logic [DATA_BITS-1:0] out_word_ff, out_word_in;
   status_type           out_status_ff, out_status_in;

   logic                 out_free;
   logic                 clamp, short0;
   status_type           err;
   logic [W-1:0]         d0, d1, shift;
   logic [W-1:0]         dur_p [2];
   logic                 lvl_p [2];
   logic [2:0]           sc3;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign q_pop    = q_valid && (!flags.last || out_free);

   always_comb begin
      d0     = dur0;
      d1     = dur1;
      err    = err_ff;
      shift  = '0;
      clamp  = first_ff && !flags.glitch && flags.below_first_short;
      if (first_ff && flags.glitch) begin
         err = STATUS_GLITCH;
      end
      if (clamp) begin
         d0 = to_dur(cfg.first_short);
      end
      short0 = clamp ? (UW'(to_dur(cfg.first_short)) < UW'(cfg.short_pulse)) : flags.short0;
      if (err == STATUS_OK && !lvl0) begin
         err = STATUS_LOW_START;
      end
      if (err == STATUS_OK && !flags.last && (short0 || flags.short1)) begin
         err = STATUS_SHORT_PULSE;
      end

      carry_in = carry_ff;
      slot_in  = slot_ff;
      bits_in  = bits_ff;
      acc_in   = acc_ff;
      stop_in  = stop_ff;
      sc3      = '0;

      if (err == STATUS_OK) begin
         d0 = d0 + carry_ff;
         if (below_long(d0, cfg.first_long, cfg.snap_tol)) begin
            if (!in_win(d0, cfg.first_short, cfg.snap_tol)) begin
               d1 = d1 + d0 - to_dur(cfg.first_short);
               d0 = to_dur(cfg.first_short);
            end
         end else if (!in_win(d0, cfg.first_long, cfg.snap_tol)) begin
            d1 = d1 + d0 - to_dur(cfg.first_long);
            d0 = to_dur(cfg.first_long);
         end

         if (below_long(d1, cfg.second_long, cfg.snap_tol)) begin
            if (!in_win(d1, cfg.second_short, cfg.snap_tol)) begin
               shift = d1 - to_dur(cfg.second_short);
               d1    = to_dur(cfg.second_short);
            end
         end else if (!in_win(d1, cfg.second_long, cfg.snap_tol)) begin
            shift = d1 - to_dur(cfg.second_long);
            d1    = to_dur(cfg.second_long);
         end
         carry_in = shift;
      end

      dur_p[0] = d0;
      dur_p[1] = d1;
      lvl_p[0] = lvl0;
      lvl_p[1] = lvl1;

      if (err == STATUS_OK) begin
         for (int p = 0; p < 2; p++) begin
            if (!stop_in) begin
               sc3 = {1'b0, slot_in} + {1'b0, slots_of(dur_p[p], cfg)};
               if (sc3 >= 3'd2) begin
                  bits_in = bits_in + BC_W'(1);
                  if (bits_in != BC_W'(1)) begin
                     acc_in = {acc_in[DATA_BITS-2:0], lvl_p[p]};
                  end
                  if (bits_in > BC_W'(DATA_BITS)) begin
                     stop_in = 1'b1;
                  end else begin
                     slot_in = 2'(sc3 - 3'd2);
                  end
               end else begin
                  slot_in = sc3[1:0];
               end
            end
         end
      end

      out_word_in   = (err == STATUS_OK) ? acc_in : '0;
      out_status_in = err;
      err_in        = err;
      first_in      = 1'b0;

      if (flags.last) begin
         carry_in = '0;
         slot_in  = 2'd1;
         bits_in  = '0;
         acc_in   = '0;
         err_in   = STATUS_OK;
         first_in = 1'b1;
         stop_in  = 1'b0;
      end

      out_valid_in = out_valid_ff && rsp_stall;
      if (q_pop && flags.last) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         carry_ff     <= '0;
         slot_ff      <= 2'd1;
         bits_ff      <= '0;
         acc_ff       <= '0;
         err_ff       <= STATUS_OK;
         first_ff     <= 1'b1;
         stop_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (q_pop) begin
            carry_ff <= carry_in;
            slot_ff  <= slot_in;
            bits_ff  <= bits_in;
            acc_ff   <= acc_in;
            err_ff   <= err_in;
            first_ff <= first_in;
            stop_ff  <= stop_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && flags.last) begin
         out_word_ff   <= out_word_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_frame_word = out_word_ff;
   assign rsp_status     = out_status_ff;

endmodule
`default_nettype wire

FILE: sv/opentherm_manchester_frame_decoder_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// opentherm_manchester_frame_decoder_core
// Decodes captured Manchester pulse symbols into a data word and status.
//
// Symbols enter on the req_ channel (valid/stall), one per cycle. Each
// carries two phase levels and durations and a last-symbol mark. Only the
// last symbol of a capture produces a transfer on the rsp_ channel: the
// decoded word and a status (ok, preamble glitch, low start, short pulse).
// Path: input register, two-entry queue, decode stage, result register.
// The decode stage is combinational from the queue head; rsp_valid rises
// when the last symbol's result is loaded into the result register.
// Sustained rate is one symbol per clock while req_stall is low.
// When rsp_stall holds a result, the decode stage keeps taking non-last
// symbols; a last symbol waits in the queue, and req_stall rises once the
// queue and input register fill.
// Reset (synchronous) restores register defaults and empties the pipeline.
// The user must write registers through csr_ while no symbol is in flight;
// the core itself does not enforce this.
// ---------------------------------------------------------------------------
module opentherm_manchester_frame_decoder_core
   import otmfd_pkg::*;
#(
   parameter int DATA_BITS     = DEF_DATA_BITS,
   parameter int DURATION_BITS = DEF_DURATION_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_wen,
   input  wire logic [INDEX_W-1:0]       csr_index,
   input  wire logic [CFG_W-1:0]         csr_wdata,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_first_level,
   input  wire logic [DURATION_BITS-1:0] req_first_duration,
   input  wire logic                     req_second_level,
   input  wire logic [DURATION_BITS-1:0] req_second_duration,
   input  wire logic                     req_last_symbol,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [DATA_BITS-1:0]          rsp_frame_word,
   output logic [1:0]                    rsp_status
);

   localparam int QW = 2 * DURATION_BITS + 2 + $bits(flags_type);

   cfg_type                  cfg_ff, cfg_in;
   logic                     q_ready, q_push, q_pop, q_valid;
   logic                     f_lvl0, f_lvl1;
   logic [DURATION_BITS-1:0] f_dur0, f_dur1;
   flags_type                f_flags;
   logic [QW-1:0]            q_in, q_head;
   logic                     b_lvl0, b_lvl1;
   logic [DURATION_BITS-1:0] b_dur0, b_dur1;
   flags_type                b_flags;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (reg_index_type'(csr_index))
            REG_FIRST_SHORT:  cfg_in.first_short  = csr_wdata;
            REG_FIRST_LONG:   cfg_in.first_long   = csr_wdata;
            REG_SECOND_SHORT: cfg_in.second_short = csr_wdata;
            REG_SECOND_LONG:  cfg_in.second_long  = csr_wdata;
            REG_SNAP_TOL:     cfg_in.snap_tol     = csr_wdata[TOL_W-1:0];
            REG_SHORT_PULSE:  cfg_in.short_pulse  = csr_wdata;
            REG_SLOT_SPLIT:   cfg_in.slot_split   = csr_wdata;
            REG_GLITCH:       cfg_in.glitch       = csr_wdata[TOL_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.first_short  <= RST_FIRST_SHORT;
         cfg_ff.first_long   <= RST_FIRST_LONG;
         cfg_ff.second_short <= RST_SECOND_SHORT;
         cfg_ff.second_long  <= RST_SECOND_LONG;
         cfg_ff.snap_tol     <= RST_SNAP_TOL;
         cfg_ff.short_pulse  <= RST_SHORT_PULSE;
         cfg_ff.slot_split   <= RST_SLOT_SPLIT;
         cfg_ff.glitch       <= RST_GLITCH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   otmfd_front #(
      .DURATION_BITS(DURATION_BITS)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg_ff),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_first_level    (req_first_level),
      .req_first_duration (req_first_duration),
      .req_second_level   (req_second_level),
      .req_second_duration(req_second_duration),
      .req_last_symbol    (req_last_symbol),
      .q_ready            (q_ready),
      .q_push             (q_push),
      .lvl0               (f_lvl0),
      .dur0               (f_dur0),
      .lvl1               (f_lvl1),
      .dur1               (f_dur1),
      .flags              (f_flags)
   );

   assign q_in = {f_lvl0, f_dur0, f_lvl1, f_dur1, f_flags};

   otmfd_queue #(
      .WIDTH(QW)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_in),
      .ready    (q_ready),
      .pop      (q_pop),
      .valid    (q_valid),
      .head     (q_head)
   );

   assign {b_lvl0, b_dur0, b_lvl1, b_dur1, b_flags} = q_head;

   otmfd_back #(
      .DATA_BITS    (DATA_BITS),
      .DURATION_BITS(DURATION_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .lvl0          (b_lvl0),
      .dur0          (b_dur0),
      .lvl1          (b_lvl1),
      .dur1          (b_dur1),
      .flags         (b_flags),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_frame_word(rsp_frame_word),
      .rsp_status    (rsp_status)
   );

endmodule
`default_nettype wire

FILE: tb/opentherm_manchester_frame_decoder_core_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// opentherm_manchester_frame_decoder_core_tb
// Self-checking bench for the Manchester frame decoder. A queue-fed driver
// sends pulse symbols over req_ while a shadow decoder computes the word and
// status of every capture; a monitor checks each rsp_ transfer against the
// oldest pending frame. Runs directed corner symbols, then encoded frames
// (some truncated, overlong or corrupted) mixed with noise captures, over
// several register settings and idle/stall patterns.
// ---------------------------------------------------------------------------
module opentherm_manchester_frame_decoder_core_tb;
   import otmfd_pkg::*;

   localparam int DATA_W         = DEF_DATA_BITS;
   localparam int DUR_W          = DEF_DURATION_BITS;
   localparam int DUR_MAX        = (1 << DUR_W) - 1;
   localparam int CLK_PERIOD     = 4;
   localparam int RESET_CYCLES   = 11;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 5000;

   typedef struct packed {
      logic             first_level;
      logic [DUR_W-1:0] first_duration;
      logic             second_level;
      logic [DUR_W-1:0] second_duration;
      logic             last_symbol;
   } symbol_type;

   typedef struct packed {
      logic [DATA_W-1:0] word;
      status_type        status;
   } frame_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                csr_wen = 1'b0;
   logic [INDEX_W-1:0]  csr_index = '0;
   logic [CFG_W-1:0]    csr_wdata = '0;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_first_level = 1'b0;
   logic [DUR_W-1:0]    req_first_duration = '0;
   logic                req_second_level = 1'b0;
   logic [DUR_W-1:0]    req_second_duration = '0;
   logic                req_last_symbol = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [DATA_W-1:0]   rsp_frame_word;
   logic [1:0]          rsp_status;

   symbol_type symbol_fifo[$];
   frame_type  pending_frames[$];
   int         symbols_queued = 0;
   int         error_count = 0;
   int         idle_cycles = 0;
   int         send_idle_pct = 0;
   int         recv_stall_pct = 0;

   cfg_type shadow_cfg = '{RST_FIRST_SHORT, RST_FIRST_LONG, RST_SECOND_SHORT,
                           RST_SECOND_LONG, RST_SNAP_TOL, RST_SHORT_PULSE,
                           RST_SLOT_SPLIT, RST_GLITCH};

   logic [DUR_W-1:0]  carry_q;
   int                slot_cnt;
   int                bit_cnt;
   logic [DATA_W-1:0] word_acc;
   status_type        capture_err;
   bit                first_sym;
   bit                decode_done;

   opentherm_manchester_frame_decoder_core dut (
      .clock               (clock),
      .reset               (reset),
      .csr_wen             (csr_wen),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_first_level     (req_first_level),
      .req_first_duration  (req_first_duration),
      .req_second_level    (req_second_level),
      .req_second_duration (req_second_duration),
      .req_last_symbol     (req_last_symbol),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_frame_word      (rsp_frame_word),
      .rsp_status          (rsp_status)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   function automatic void clear_capture_state();
      carry_q     = '0;
      slot_cnt    = 1;
      bit_cnt     = 0;
      word_acc    = '0;
      capture_err = STATUS_OK;
      first_sym   = 1'b1;
      decode_done = 1'b0;
   endfunction

   function automatic bit within_window(int len, int base, int tol);
      return (len > base - tol) && (len < base + tol);
   endfunction

   function automatic bit short_of_long(int len, int lng, int tol);
      return len < lng - 2 * tol;
   endfunction

   function automatic int slot_weight(logic [DUR_W-1:0] d);
      if (d < shadow_cfg.glitch) return 0;
      if (d < shadow_cfg.slot_split) return 1;
      return 2;
   endfunction

   function automatic void advance_bits(logic [DUR_W-1:0] d, logic level);
      if (decode_done) return;
      slot_cnt += slot_weight(d);
      if (slot_cnt >= 2) begin
         bit_cnt++;
         if (bit_cnt != 1) word_acc = {word_acc[DATA_W-2:0], level};
         if (bit_cnt > DATA_W) begin
            decode_done = 1'b1;
            return;
         end
         slot_cnt -= 2;
      end
      slot_cnt &= 3;
   endfunction

   function automatic void decode_symbol(symbol_type s);
      logic [DUR_W-1:0] d0;
      logic [DUR_W-1:0] d1;
      logic [DUR_W-1:0] shift;
      int               tol;
      frame_type        f;
      d0    = s.first_duration;
      d1    = s.second_duration;
      shift = '0;
      tol   = shadow_cfg.snap_tol;
      if (first_sym) begin
         if (d0 < shadow_cfg.glitch || d1 < shadow_cfg.glitch) capture_err = STATUS_GLITCH;
         else if (d0 < shadow_cfg.first_short) d0 = shadow_cfg.first_short;
      end
      if (capture_err == STATUS_OK && !s.first_level) capture_err = STATUS_LOW_START;
      if (capture_err == STATUS_OK && !s.last_symbol &&
          (d0 < shadow_cfg.short_pulse || d1 < shadow_cfg.short_pulse))
         capture_err = STATUS_SHORT_PULSE;
      if (capture_err == STATUS_OK) begin
         d0 = d0 + carry_q;
         if (short_of_long(d0, shadow_cfg.first_long, tol)) begin
            if (!within_window(d0, shadow_cfg.first_short, tol)) begin
               d1 = d1 + d0 - shadow_cfg.first_short;
               d0 = shadow_cfg.first_short;
            end
         end else if (!within_window(d0, shadow_cfg.first_long, tol)) begin
            d1 = d1 + d0 - shadow_cfg.first_long;
            d0 = shadow_cfg.first_long;
         end
         if (short_of_long(d1, shadow_cfg.second_long, tol)) begin
            if (!within_window(d1, shadow_cfg.second_short, tol)) begin
               shift = d1 - shadow_cfg.second_short;
               d1    = shadow_cfg.second_short;
            end
         end else if (!within_window(d1, shadow_cfg.second_long, tol)) begin
            shift = d1 - shadow_cfg.second_long;
            d1    = shadow_cfg.second_long;
         end
         carry_q = shift;
         advance_bits(d0, s.first_level);
         advance_bits(d1, s.second_level);
      end
      first_sym = 1'b0;
      if (s.last_symbol) begin
         f.word   = (capture_err == STATUS_OK) ? word_acc : {DATA_W{1'b0}};
         f.status = capture_err;
         pending_frames.insert(pending_frames.size(), f);
         clear_capture_state();
      end
   endfunction

   // driver: hold the payload until transfer, then advance
   always @(posedge clock) begin : driver
      logic       busy;
      symbol_type next_sym;
      if (!reset) begin
         busy = req_valid;
         if (req_valid && !req_stall) begin
            decode_symbol({req_first_level, req_first_duration, req_second_level,
                           req_second_duration, req_last_symbol});
            busy = 1'b0;
         end
         if (!busy) begin
            if (symbol_fifo.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               next_sym  = symbol_fifo.pop_front();
               req_valid <= 1'b1;
               {req_first_level, req_first_duration, req_second_level,
                req_second_duration, req_last_symbol} <= next_sym;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      frame_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_frames.size() == 0) begin
            $display("%0t: unexpected frame: word %h status %0d", $time,
                     rsp_frame_word, rsp_status);
            error_count++;
         end else begin
            want = pending_frames.pop_front();
            if (rsp_frame_word !== want.word) begin
               $display("%0t: frame word mismatch: expected %h actual %h", $time,
                        want.word, rsp_frame_word);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d actual %0d", $time,
                        want.status, rsp_status);
               error_count++;
            end
         end
      end
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   function automatic void push_symbol(symbol_type s);
      symbol_fifo.insert(symbol_fifo.size(), s);
      symbols_queued++;
   endfunction

   function automatic logic [DUR_W-1:0] jittered(int nominal, int span);
      int v;
      v = nominal - span + int'($urandom_range(2 * span));
      if (v < 0) v = 0;
      if (v > DUR_MAX) v = DUR_MAX;
      return DUR_W'(v);
   endfunction

   // Manchester-encode a random word with start and stop bits
   task automatic push_frame();
      logic [DATA_W-1:0] payload;
      bit                halves[$];
      int                run_len[$];
      bit                run_lvl[$];
      symbol_type        frame_syms[$];
      symbol_type        sym;
      int                k;
      int                span;
      int                n_pairs;
      bit                extra_bit;
      payload = $urandom;
      halves.insert(halves.size(), 1'b1);
      halves.insert(halves.size(), 1'b0);
      for (k = DATA_W - 1; k >= 0; k--) begin
         halves.insert(halves.size(), payload[k]);
         halves.insert(halves.size(), !payload[k]);
      end
      halves.insert(halves.size(), 1'b1);
      halves.insert(halves.size(), 1'b0);
      case ($urandom_range(7))
         0: repeat ($urandom_range(1, 3)) begin
               extra_bit = $urandom_range(1);
               halves.insert(halves.size(), extra_bit);
               halves.insert(halves.size(), !extra_bit);
            end
         1: repeat ($urandom_range(2, 60)) void'(halves.pop_back());
         default: ;
      endcase
      foreach (halves[i]) begin
         if (i > 0 && halves[i] == halves[i-1]) begin
            run_len[run_len.size()-1] += 1;
         end else begin
            run_len.insert(run_len.size(), 1);
            run_lvl.insert(run_lvl.size(), halves[i]);
         end
      end
      if (run_len.size() % 2) begin
         run_len.insert(run_len.size(), 1);
         run_lvl.insert(run_lvl.size(), !run_lvl[run_lvl.size()-1]);
      end
      span    = 3 * int'(shadow_cfg.snap_tol) + 20;
      n_pairs = run_len.size() / 2;
      for (k = 0; k < n_pairs; k++) begin
         sym.first_level     = run_lvl[2*k];
         sym.first_duration  = jittered((run_len[2*k] == 1) ? int'(shadow_cfg.first_short)
                                                            : int'(shadow_cfg.first_long), span);
         sym.second_level    = run_lvl[2*k+1];
         sym.second_duration = jittered((run_len[2*k+1] == 1) ? int'(shadow_cfg.second_short)
                                                              : int'(shadow_cfg.second_long), span);
         sym.last_symbol     = (k == n_pairs - 1);
         frame_syms.insert(frame_syms.size(), sym);
      end
      if ($urandom_range(7) == 0) begin
         k = $urandom_range(n_pairs - 1);
         case ($urandom_range(3))
            0: frame_syms[k].first_level = !frame_syms[k].first_level;
            1: frame_syms[k].first_duration = DUR_W'($urandom);
            2: frame_syms[k].second_duration = DUR_W'($urandom_range(0, 200));
            default: frame_syms[k].second_level = !frame_syms[k].second_level;
         endcase
      end
      foreach (frame_syms[i]) push_symbol(frame_syms[i]);
   endtask

   task automatic push_noise();
      symbol_type s;
      int         n;
      n = $urandom_range(1, 4);
      for (int k = 0; k < n; k++) begin
         s.first_level     = $urandom_range(1);
         s.first_duration  = $urandom_range(1) ? DUR_W'($urandom) : DUR_W'($urandom_range(0, 200));
         s.second_level    = $urandom_range(1);
         s.second_duration = $urandom_range(1) ? DUR_W'($urandom) : DUR_W'($urandom_range(0, 200));
         s.last_symbol     = (k == n - 1);
         push_symbol(s);
      end
   endtask

   task automatic run_captures(int count);
      int stop_at;
      stop_at = symbols_queued + count;
      while (symbols_queued < stop_at) begin
         if ($urandom_range(99) < 75) push_frame();
         else push_noise();
         @(negedge clock);
      end
   endtask

   // wait for every frame, then idle so the pipeline settles
   task automatic drain();
      do @(negedge clock);
      while (symbol_fifo.size() != 0 || req_valid || pending_frames.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_config(cfg_type c);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= REG_FIRST_SHORT;
      csr_wdata <= c.first_short;
      @(posedge clock);
      csr_index <= REG_FIRST_LONG;
      csr_wdata <= c.first_long;
      @(posedge clock);
      csr_index <= REG_SECOND_SHORT;
      csr_wdata <= c.second_short;
      @(posedge clock);
      csr_index <= REG_SECOND_LONG;
      csr_wdata <= c.second_long;
      @(posedge clock);
      csr_index <= REG_SNAP_TOL;
      csr_wdata <= CFG_W'(c.snap_tol);
      @(posedge clock);
      csr_index <= REG_SHORT_PULSE;
      csr_wdata <= c.short_pulse;
      @(posedge clock);
      csr_index <= REG_SLOT_SPLIT;
      csr_wdata <= c.slot_split;
      @(posedge clock);
      csr_index <= REG_GLITCH;
      csr_wdata <= CFG_W'(c.glitch);
      @(posedge clock);
      csr_wen    <= 1'b0;
      shadow_cfg = c;
   endtask

   initial begin : stimulus
      cfg_type c;
      int      fs;
      clear_capture_state();
      send_idle_pct  = 20;
      recv_stall_pct = 71;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      push_symbol('{1'b1, 15'd0, 1'b0, 15'd470, 1'b1});
      push_symbol('{1'b1, 15'd32767, 1'b0, 15'd29, 1'b0});
      push_symbol('{1'b1, 15'd550, 1'b0, 15'd470, 1'b1});
      push_symbol('{1'b0, 15'd550, 1'b1, 15'd470, 1'b1});
      push_symbol('{1'b1, 15'd600, 1'b0, 15'd100, 1'b0});
      push_symbol('{1'b1, 15'd550, 1'b0, 15'd470, 1'b1});
      push_symbol('{1'b1, 15'd32767, 1'b1, 15'd32767, 1'b1});
      push_symbol('{1'b1, 15'd200, 1'b0, 15'd470, 1'b0});
      push_symbol('{1'b1, 15'd1060, 1'b0, 15'd984, 1'b1});
      push_symbol('{1'b1, 15'd550, 1'b0, 15'd470, 1'b0});
      push_symbol('{1'b0, 15'd550, 1'b1, 15'd470, 1'b1});
      push_symbol('{1'b1, 15'd550, 1'b0, 15'd470, 1'b0});
      push_symbol('{1'b1, 15'd550, 1'b0, 15'd40, 1'b1});
      push_symbol('{1'b1, 15'd30, 1'b0, 15'd30, 1'b1});
      run_captures(480);
      drain();

      fs             = $urandom_range(300, 700);
      c.first_short  = CFG_W'(fs);
      c.first_long   = CFG_W'(2 * fs - 40 + int'($urandom_range(80)));
      c.second_short = CFG_W'(fs - int'($urandom_range(100)));
      c.second_long  = CFG_W'(2 * fs - int'($urandom_range(100)));
      c.snap_tol     = TOL_W'($urandom_range(5, 80));
      c.short_pulse  = CFG_W'(fs / 4);
      c.slot_split   = CFG_W'(3 * fs / 2);
      c.glitch       = TOL_W'($urandom_range(5, 60));
      load_config(c);
      run_captures(450);
      drain();

      send_idle_pct  = 71;
      recv_stall_pct = 20;
      load_config('0);
      run_captures(150);
      drain();

      load_config('1);
      run_captures(150);
      drain();

      send_idle_pct  = 0;
      recv_stall_pct = 0;
      c.first_short  = CFG_W'($urandom);
      c.first_long   = CFG_W'($urandom);
      c.second_short = CFG_W'($urandom);
      c.second_long  = CFG_W'($urandom);
      c.snap_tol     = TOL_W'($urandom);
      c.short_pulse  = CFG_W'($urandom);
      c.slot_split   = CFG_W'($urandom);
      c.glitch       = TOL_W'($urandom);
      load_config(c);
      run_captures(270);
      drain();

      load_config('{RST_FIRST_SHORT, RST_FIRST_LONG, RST_SECOND_SHORT, RST_SECOND_LONG,
                    RST_SNAP_TOL, RST_SHORT_PULSE, RST_SLOT_SPLIT, RST_GLITCH});
      run_captures(450);
      drain();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
